// ----- src/tch_pkg.sv -----
// ----------------------------------------------------------------------------
// tch_pkg
// Types, codes and microcode word layout of the text console character handler.
// ----------------------------------------------------------------------------
package tch_pkg;

	localparam int COL_W         = 7;
	localparam int ROW_W         = 6;
	localparam int MAX_TAB_WIDTH = 16;
	localparam int FF_LINES      = 80;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] CFG_TEXT_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_TEXT_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TAB_WIDTH   = 2'd2;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_SCROLL,
		KIND_BEEP,
		KIND_REPORT
	} tch_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PUT,
		ST_SCR1,
		ST_LF,
		ST_CR,
		ST_FF,
		ST_FF_SCR,
		ST_TAB,
		ST_TAB_DIV,
		ST_TAB_N,
		ST_TAB_PUT,
		ST_TAB_SCR,
		ST_TAB_CHK,
		ST_BS,
		ST_BS_MOVE,
		ST_BS_BLANK,
		ST_BEL,
		ST_DEL,
		ST_REPORT
	} tch_step_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_PUT,
		OP_LF,
		OP_CR,
		OP_FF,
		OP_DIV_INIT,
		OP_DIV,
		OP_TAB_N,
		OP_BS_MOVE
	} tch_op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NEED_SCROLL,
		C_BOTTOM,
		C_REST_NZ,
		C_SH_ZERO,
		C_CNT_ZERO,
		C_ORIGIN
	} tch_cond_t;

	typedef enum logic [1:0] {
		CHR_ZERO,
		CHR_CODE,
		CHR_SPACE
	} tch_chr_sel_t;

	typedef enum logic [1:0] {
		LN_ZERO,
		LN_ONE,
		LN_REST
	} tch_ln_sel_t;

	typedef struct packed {
		tch_op_t      op;
		logic         emit;
		tch_kind_t    kind;
		logic         pos_en;
		tch_chr_sel_t chr_sel;
		tch_ln_sel_t  ln_sel;
		tch_cond_t    cond;
		tch_step_t    jump_t;
		tch_step_t    jump_f;
	} tch_uop_t;

	typedef struct packed {
		tch_uop_t uop;
		logic     adv;
		logic     take_char;
	} tch_ctrl_t;

	typedef struct packed {
		logic need_scroll;
		logic bottom;
		logic rest_nz;
		logic sh_zero;
		logic cnt_zero;
		logic origin;
		logic out_busy;
	} tch_stat_t;

	typedef struct packed {
		logic [7:0] char_code;
	} tch_char_t;

	typedef struct packed {
		logic [1:0]       action_kind;
		logic [COL_W-1:0] cell_column;
		logic [ROW_W-1:0] cell_row;
		logic [7:0]       cell_char;
		logic [6:0]       scroll_lines;
		logic             last_action;
	} tch_action_t;

	typedef struct packed {
		logic [1:0] reg_index;
		logic [7:0] reg_data;
	} tch_cfg_t;

endpackage

// ----- src/tch_chan_if.sv -----
// ----------------------------------------------------------------------------
// tch_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface tch_chan_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/text_console_char_handler_core.sv -----
// The character beat sets the step counter; each action beat is registered in the action
// output register. A new character is taken only when idle, after the report beat of the
// last one. LF, CR and form feed add one step that emits nothing, backspace up to two; tabs
// add the stop divider steps and a check step per space; the sequencer holds while the action
// output register is full. Reset: cursor at column 0 row 0, width 80, height 25, tab 8, idle.
// ----------------------------------------------------------------------------
// text_console_char_handler_core
// Text console control character handler, microcoded sequencer top level.
// ----------------------------------------------------------------------------
module text_console_char_handler_core (
	input logic        clk,
	input logic        arst_n,
	tch_chan_if.sink   char_in,
	tch_chan_if.source action_out,
	tch_chan_if.sink   cfg
);
	import tch_pkg::*;

	tch_ctrl_t   ctrl;
	tch_stat_t   stat;
	tch_char_t   char_beat;
	tch_cfg_t    cfg_beat;
	tch_action_t act_beat;

	assign char_beat = char_in.payload;
	assign cfg_beat  = cfg.payload;
	assign cfg.ready = 1'b1;

	tch_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (char_in.valid),
		.char_code (char_beat.char_code),
		.in_ready  (char_in.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	tch_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.char_code (char_beat.char_code),
		.cfg_we    (cfg.valid),
		.cfg_beat  (cfg_beat),
		.stat      (stat),
		.out_valid (action_out.valid),
		.out_ready (action_out.ready),
		.out_beat  (act_beat)
	);

	assign action_out.payload = act_beat;
endmodule

// ----- src/tch_ucode_rom.sv -----
// ----------------------------------------------------------------------------
// tch_ucode_rom
// Control store: one control word per sequencer step.
// ----------------------------------------------------------------------------
module tch_ucode_rom (
	input  tch_pkg::tch_step_t step,
	output tch_pkg::tch_uop_t  uop
);
	import tch_pkg::*;

	always_comb begin
		unique case (step)
			ST_PUT:      uop = '{OP_PUT, 1'b1, KIND_WRITE, 1'b1, CHR_CODE, LN_ZERO,
				C_NEED_SCROLL, ST_SCR1, ST_REPORT};
			ST_SCR1:     uop = '{OP_NONE, 1'b1, KIND_SCROLL, 1'b0, CHR_ZERO, LN_ONE,
				C_ALWAYS, ST_REPORT, ST_REPORT};
			ST_LF:       uop = '{OP_LF, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_BOTTOM, ST_SCR1, ST_REPORT};
			ST_CR:       uop = '{OP_CR, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_REPORT, ST_REPORT};
			ST_FF:       uop = '{OP_FF, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_REST_NZ, ST_FF_SCR, ST_REPORT};
			ST_FF_SCR:   uop = '{OP_NONE, 1'b1, KIND_SCROLL, 1'b0, CHR_ZERO, LN_REST,
				C_ALWAYS, ST_REPORT, ST_REPORT};
			ST_TAB:      uop = '{OP_DIV_INIT, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_TAB_DIV, ST_TAB_DIV};
			ST_TAB_DIV:  uop = '{OP_DIV, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_SH_ZERO, ST_TAB_N, ST_TAB_DIV};
			ST_TAB_N:    uop = '{OP_TAB_N, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_TAB_PUT, ST_TAB_PUT};
			ST_TAB_PUT:  uop = '{OP_PUT, 1'b1, KIND_WRITE, 1'b1, CHR_SPACE, LN_ZERO,
				C_NEED_SCROLL, ST_TAB_SCR, ST_TAB_CHK};
			ST_TAB_SCR:  uop = '{OP_NONE, 1'b1, KIND_SCROLL, 1'b0, CHR_ZERO, LN_ONE,
				C_ALWAYS, ST_TAB_CHK, ST_TAB_CHK};
			ST_TAB_CHK:  uop = '{OP_NONE, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_CNT_ZERO, ST_REPORT, ST_TAB_PUT};
			ST_BS:       uop = '{OP_NONE, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_ORIGIN, ST_REPORT, ST_BS_MOVE};
			ST_BS_MOVE:  uop = '{OP_BS_MOVE, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_BS_BLANK, ST_BS_BLANK};
			ST_BS_BLANK: uop = '{OP_NONE, 1'b1, KIND_WRITE, 1'b1, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_REPORT, ST_REPORT};
			ST_BEL:      uop = '{OP_NONE, 1'b1, KIND_BEEP, 1'b0, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_REPORT, ST_REPORT};
			ST_DEL:      uop = '{OP_NONE, 1'b1, KIND_WRITE, 1'b1, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_REPORT, ST_REPORT};
			ST_REPORT:   uop = '{OP_NONE, 1'b1, KIND_REPORT, 1'b1, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_IDLE, ST_IDLE};
			default:     uop = '{OP_NONE, 1'b0, KIND_WRITE, 1'b0, CHR_ZERO, LN_ZERO,
				C_ALWAYS, ST_IDLE, ST_IDLE};
		endcase
	end
endmodule

// ----- src/tch_datapath.sv -----
// ----------------------------------------------------------------------------
// tch_datapath
// Cursor, configuration and scratch registers, tab stop divider and action
// output register, driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module tch_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tch_pkg::tch_ctrl_t   ctrl,
	input  logic [7:0]           char_code,
	input  logic                 cfg_we,
	input  tch_pkg::tch_cfg_t    cfg_beat,
	output tch_pkg::tch_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tch_pkg::tch_action_t out_beat
);
	import tch_pkg::*;

	localparam int          DVS_W   = 5 + COL_W - 1;
	localparam int          REM_EXT = DVS_W - COL_W;
	localparam logic [2:0]  SH_TOP  = 3'(COL_W - 1);
	localparam logic [8:0]  FF9     = 9'(FF_LINES);

	logic [7:0]       width_q;
	logic [6:0]       height_q;
	logic [4:0]       tab_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       ch_q;
	logic [4:0]       cnt_q;
	logic [COL_W-1:0] rem_q;
	logic [2:0]       sh_q;
	logic [6:0]       rest_q;
	logic             out_valid_q;
	tch_action_t      out_q;

	logic [7:0]       w_eff;
	logic [6:0]       h_eff;
	logic [4:0]       t_eff;
	logic [7:0]       col_inc;
	logic [6:0]       row_inc;
	logic             wrap;
	logic             bottom;
	logic [6:0]       down;
	logic [8:0]       down_c;
	logic [8:0]       rest9;
	logic [6:0]       rest_next;
	logic [DVS_W-1:0] dvs;
	logic [DVS_W-1:0] rem_ext;
	logic [DVS_W-1:0] rem_sub;
	logic             rem_ge;
	logic             load;
	logic [7:0]       wm1;
	tch_action_t      beat_d;

	always_comb begin
		w_eff = (width_q == 8'd0) ? 8'd1 : ((width_q > 8'd128) ? 8'd128 : width_q);
		h_eff = (height_q == 7'd0) ? 7'd1 : ((height_q > 7'd64) ? 7'd64 : height_q);
		t_eff = (tab_q == 5'd0) ? 5'd1 :
			((tab_q > 5'(MAX_TAB_WIDTH)) ? 5'(MAX_TAB_WIDTH) : tab_q);
		col_inc = {1'b0, col_q} + 8'd1;
		row_inc = {1'b0, row_q} + 7'd1;
		wrap    = col_inc >= w_eff;
		bottom  = row_inc >= h_eff;
		down    = bottom ? 7'd0 : (h_eff - row_inc);
		down_c  = ({2'b00, down} > FF9) ? FF9 : {2'b00, down};
		rest9   = FF9 - down_c;
		rest_next = (rest9 > 9'd127) ? 7'd127 : rest9[6:0];
		dvs     = {{(DVS_W-5){1'b0}}, t_eff} << sh_q;
		rem_ext = {{REM_EXT{1'b0}}, rem_q};
		rem_ge  = rem_ext >= dvs;
		rem_sub = rem_ext - dvs;
		wm1     = w_eff - 8'd1;
	end

	always_comb begin
		stat.need_scroll = wrap && bottom;
		stat.bottom      = bottom;
		stat.rest_nz     = rest_next != 7'd0;
		stat.sh_zero     = sh_q == 3'd0;
		stat.cnt_zero    = cnt_q == 5'd0;
		stat.origin      = (col_q == '0) && (row_q == '0);
		stat.out_busy    = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd80;
			height_q <= 7'd25;
			tab_q    <= 5'd8;
		end else if (cfg_we) begin
			unique case (cfg_beat.reg_index)
				CFG_TEXT_WIDTH:  width_q  <= cfg_beat.reg_data;
				CFG_TEXT_HEIGHT: height_q <= cfg_beat.reg_data[6:0];
				CFG_TAB_WIDTH:   tab_q    <= cfg_beat.reg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctrl.adv) begin
			unique case (ctrl.uop.op)
				OP_PUT: begin
					if (wrap) begin
						col_q <= '0;
						if (!bottom) row_q <= row_inc[ROW_W-1:0];
					end else begin
						col_q <= col_inc[COL_W-1:0];
					end
				end
				OP_LF: begin
					col_q <= '0;
					if (!bottom) row_q <= row_inc[ROW_W-1:0];
				end
				OP_CR: col_q <= '0;
				OP_FF: begin
					col_q <= '0;
					row_q <= '0;
				end
				OP_BS_MOVE: begin
					if (col_q == '0) begin
						col_q <= wm1[COL_W-1:0];
						row_q <= row_q - ROW_W'(1);
					end else begin
						col_q <= col_q - COL_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take_char) ch_q <= char_code;
		if (ctrl.adv) begin
			unique case (ctrl.uop.op)
				OP_PUT:      cnt_q <= cnt_q - 5'd1;
				OP_FF:       rest_q <= rest_next;
				OP_DIV_INIT: begin
					rem_q <= col_q;
					sh_q  <= SH_TOP;
				end
				OP_DIV: begin
					if (rem_ge) rem_q <= rem_sub[COL_W-1:0];
					sh_q <= sh_q - 3'd1;
				end
				OP_TAB_N:    cnt_q <= t_eff - rem_q[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		beat_d.action_kind = ctrl.uop.kind;
		beat_d.cell_column = ctrl.uop.pos_en ? col_q : '0;
		beat_d.cell_row    = ctrl.uop.pos_en ? row_q : '0;
		unique case (ctrl.uop.chr_sel)
			CHR_CODE:  beat_d.cell_char = ch_q;
			CHR_SPACE: beat_d.cell_char = CH_SPACE;
			default:   beat_d.cell_char = 8'd0;
		endcase
		unique case (ctrl.uop.ln_sel)
			LN_ONE:  beat_d.scroll_lines = 7'd1;
			LN_REST: beat_d.scroll_lines = rest_q;
			default: beat_d.scroll_lines = 7'd0;
		endcase
		beat_d.last_action = ctrl.uop.kind == KIND_REPORT;
	end

	assign load = ctrl.adv && ctrl.uop.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= beat_d;
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;
endmodule

// ----- src/tch_seq.sv -----
// ----------------------------------------------------------------------------
// tch_seq
// Step counter with dispatch on the character code and conditional jumps
// taken from the control store.
// ----------------------------------------------------------------------------
module tch_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         char_code,
	output logic               in_ready,
	input  tch_pkg::tch_stat_t stat,
	output tch_pkg::tch_ctrl_t ctrl
);
	import tch_pkg::*;

	tch_step_t step_q;
	tch_step_t step_d;
	tch_uop_t  uop;
	logic      idle;
	logic      stall;
	logic      cond_met;

	function automatic tch_step_t dispatch(input logic [7:0] code);
		unique case (code)
			CH_NUL:  dispatch = ST_IDLE;
			CH_LF:   dispatch = ST_LF;
			CH_CR:   dispatch = ST_CR;
			CH_FF:   dispatch = ST_FF;
			CH_TAB:  dispatch = ST_TAB;
			CH_BS:   dispatch = ST_BS;
			CH_BEL:  dispatch = ST_BEL;
			CH_DEL:  dispatch = ST_DEL;
			default: dispatch = ST_PUT;
		endcase
	endfunction

	tch_ucode_rom u_rom (
		.step (step_q),
		.uop  (uop)
	);

	always_comb begin
		unique case (uop.cond)
			C_NEED_SCROLL: cond_met = stat.need_scroll;
			C_BOTTOM:      cond_met = stat.bottom;
			C_REST_NZ:     cond_met = stat.rest_nz;
			C_SH_ZERO:     cond_met = stat.sh_zero;
			C_CNT_ZERO:    cond_met = stat.cnt_zero;
			C_ORIGIN:      cond_met = stat.origin;
			default:       cond_met = 1'b1;
		endcase
	end

	assign idle  = step_q == ST_IDLE;
	assign stall = uop.emit && stat.out_busy;

	always_comb begin
		priority if (idle) begin
			step_d = in_valid ? dispatch(char_code) : ST_IDLE;
		end else if (stall) begin
			step_d = step_q;
		end else begin
			step_d = cond_met ? uop.jump_t : uop.jump_f;
		end
	end

	always_comb begin
		in_ready       = idle;
		ctrl.uop       = uop;
		ctrl.adv       = !idle && !stall;
		ctrl.take_char = idle && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end
endmodule

// ----- src/tch_checker.sv -----
// ----------------------------------------------------------------------------
// tch_checker
// Port-level checks of the character handler, bound to the top level.
// ----------------------------------------------------------------------------
module tch_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_code,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_last,
	input logic [1:0] out_kind
);
	import tch_pkg::*;

	logic [1:0] pending_q;
	logic       in_beat;
	logic       last_beat;

	assign in_beat   = in_valid && in_ready && (in_code != CH_NUL);
	assign last_beat = out_valid && out_ready && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, in_beat} - {1'b0, last_beat};
		end
	end

	a_accept_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |->
			(pending_q == 2'd0) || (pending_q == 2'd1 && out_valid && out_last))
		else $error("character taken while an earlier one is still in progress");

	a_no_orphan_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("action beat without a character in progress");

	a_last_is_report: assert property (@(posedge clk) disable iff (!arst_n)
		last_beat |=> !(out_valid && out_last) || pending_q != 2'd0)
		else $error("report repeated after the final beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
		else $error("action beat dropped or changed while stalled");
endmodule

bind text_console_char_handler_core tch_checker u_tch_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (char_in.valid),
	.in_ready  (char_in.ready),
	.in_code   (char_in.payload.char_code),
	.out_valid (action_out.valid),
	.out_ready (action_out.ready),
	.out_last  (action_out.payload.last_action),
	.out_kind  (action_out.payload.action_kind)
);
